/* design/sfd_pkg.sv */
// sfd_pkg: types and constants shared by the serial frame deframer
// used by sfd_if.sv, sfd_size_lookup.sv and serial_frame_deframer_core.sv
package sfd_pkg;

    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned NUM_SLOTS     = 4;
    localparam int unsigned NUM_CFG_REGS  = 2 * NUM_SLOTS;
    localparam int unsigned CFG_INDEX_W   = 8;
    localparam int unsigned CFG_DATA_W    = BYTE_W;
    localparam int unsigned SLOT_SEL_W    = $clog2(NUM_SLOTS);

    localparam int unsigned ARRAY_PAYLOAD_BYTES_DEF = 128;

    localparam logic [BYTE_W-1:0] HDR_BYTE = 8'h55;
    localparam logic [BYTE_W-1:0] ARRAY_ID = 8'hff;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_ID      = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_CHECK   = 2'd3
    } phase_t;

    // slot table handed from the register bank to the size lookup
    typedef struct packed {
        byte_t [NUM_SLOTS-1:0] id;
        byte_t [NUM_SLOTS-1:0] size;
    } slot_table_t;

endpackage

/* design/sfd_if.sv */
// sfd_if: valid/ready channels of the deframer, received bytes and results
// depends on sfd_pkg
interface sfd_rx_if;
    logic          valid;
    logic          ready;
    sfd_pkg::byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_res_if;
    logic           valid;
    logic           ready;
    sfd_pkg::byte_t out_byte;
    sfd_pkg::byte_t packet_id;
    logic           frame_end;
    logic           frame_ok;

    modport source (output valid, output out_byte, output packet_id,
                    output frame_end, output frame_ok, input ready);
    modport sink   (input valid, input out_byte, input packet_id,
                    input frame_end, input frame_ok, output ready);
endinterface

/* design/sfd_size_lookup.sv */
// sfd_size_lookup: payload length for a packet id from the slot table
// depends on sfd_pkg
module sfd_size_lookup #(
    parameter int unsigned ARRAY_PAYLOAD_BYTES = sfd_pkg::ARRAY_PAYLOAD_BYTES_DEF
) (
    input  sfd_pkg::slot_table_t table_in,
    input  sfd_pkg::byte_t       id,
    output sfd_pkg::byte_t       size
);

    localparam logic [sfd_pkg::BYTE_W-1:0] ARRAY_LEN =
        sfd_pkg::BYTE_W'(ARRAY_PAYLOAD_BYTES);

    logic [sfd_pkg::NUM_SLOTS-1:0] hit;
    sfd_pkg::byte_t                slot_size;

    always_comb
    begin
        for (int k = 0; k < sfd_pkg::NUM_SLOTS; k++)
        begin
            hit[k] = (table_in.id[k] == id);
        end
    end

    // lowest matching slot wins, slot 0 when nothing matches
    always_comb
    begin
        slot_size = table_in.size[0];
        for (int k = sfd_pkg::NUM_SLOTS - 1; k >= 0; k--)
        begin
            if (hit[k])
            begin
                slot_size = table_in.size[k];
            end
        end
    end

    assign size = (id == sfd_pkg::ARRAY_ID) ? ARRAY_LEN : slot_size;

endmodule

/* design/serial_frame_deframer_core.sv */
// serial_frame_deframer_core: header / id / payload / checksum deframer
// depends on sfd_pkg, sfd_if (sfd_rx_if, sfd_res_if) and sfd_size_lookup
//
//  channel  dir  payload                                   transfer
//  rx       in   rx_byte                                   valid && ready
//  res      out  out_byte, packet_id, frame_end, frame_ok  valid && ready
//  cfg      in   cfg_index, cfg_wdata                      cfg_we
//
//  one byte per clock; each byte is decoded in the cycle it is taken and
//  any result lands in the output register on the same edge
//  rx.ready is low only while a result is held and res.ready is low
//  reset leaves the deframer hunting for a header with a cleared slot table
//  slot table to be written only between frames; the user must ensure it
module serial_frame_deframer_core #(
    parameter int unsigned ARRAY_PAYLOAD_BYTES = sfd_pkg::ARRAY_PAYLOAD_BYTES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    sfd_rx_if.sink                             rx,
    sfd_res_if.source                          res,
    input  logic                               cfg_we,
    input  logic [sfd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sfd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    sfd_pkg::slot_table_t table_reg;
    sfd_pkg::phase_t      phase_reg, phase_next;
    sfd_pkg::byte_t       id_reg, id_next;
    sfd_pkg::byte_t       left_reg, left_next;
    sfd_pkg::byte_t       sum_reg, sum_next;
    logic                 out_valid_reg, out_valid_next;
    sfd_pkg::byte_t       out_byte_reg, out_byte_next;
    sfd_pkg::byte_t       out_id_reg, out_id_next;
    logic                 out_end_reg, out_end_next;
    logic                 out_ok_reg, out_ok_next;
    sfd_pkg::byte_t       size;
    logic                 in_fire;

    // slot register bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_reg <= '0;
        end
        else if (cfg_we && (cfg_index < sfd_pkg::CFG_INDEX_W'(sfd_pkg::NUM_CFG_REGS)))
        begin
            if (cfg_index[0])
            begin
                table_reg.size[cfg_index[sfd_pkg::SLOT_SEL_W:1]] <= cfg_wdata;
            end
            else
            begin
                table_reg.id[cfg_index[sfd_pkg::SLOT_SEL_W:1]] <= cfg_wdata;
            end
        end
    end

    sfd_size_lookup #(
        .ARRAY_PAYLOAD_BYTES(ARRAY_PAYLOAD_BYTES)
    ) u_size_lookup (
        .table_in (table_reg),
        .id       (rx.rx_byte),
        .size     (size)
    );

    assign rx.ready = !out_valid_reg || res.ready;
    assign in_fire  = rx.valid && rx.ready;

    always_comb
    begin
        phase_next     = phase_reg;
        id_next        = id_reg;
        left_next      = left_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_byte_next  = out_byte_reg;
        out_id_next    = out_id_reg;
        out_end_next   = out_end_reg;
        out_ok_next    = out_ok_reg;
        if (in_fire)
        begin
            unique case (phase_reg)
                sfd_pkg::PH_HUNT:
                begin
                    if (rx.rx_byte == sfd_pkg::HDR_BYTE)
                    begin
                        sum_next   = sfd_pkg::HDR_BYTE;
                        phase_next = sfd_pkg::PH_ID;
                    end
                end
                sfd_pkg::PH_ID:
                begin
                    id_next    = rx.rx_byte;
                    sum_next   = sum_reg + rx.rx_byte;
                    left_next  = size;
                    phase_next = (size == '0) ? sfd_pkg::PH_CHECK : sfd_pkg::PH_PAYLOAD;
                end
                sfd_pkg::PH_PAYLOAD:
                begin
                    sum_next       = sum_reg + rx.rx_byte;
                    left_next      = left_reg - 8'd1;
                    phase_next     = (left_reg == 8'd1) ? sfd_pkg::PH_CHECK
                                                        : sfd_pkg::PH_PAYLOAD;
                    out_valid_next = 1'b1;
                    out_byte_next  = rx.rx_byte;
                    out_id_next    = id_reg;
                    out_end_next   = 1'b0;
                    out_ok_next    = 1'b0;
                end
                sfd_pkg::PH_CHECK:
                begin
                    phase_next     = sfd_pkg::PH_HUNT;
                    left_next      = '0;
                    out_valid_next = 1'b1;
                    out_byte_next  = rx.rx_byte;
                    out_id_next    = id_reg;
                    out_end_next   = 1'b1;
                    out_ok_next    = (sum_reg == rx.rx_byte);
                end
                default:
                begin
                    phase_next = sfd_pkg::PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= sfd_pkg::PH_HUNT;
            id_reg        <= '0;
            left_reg      <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            id_reg        <= id_next;
            left_reg      <= left_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_id_reg   <= out_id_next;
        out_end_reg  <= out_end_next;
        out_ok_reg   <= out_ok_next;
    end

    assign res.valid     = out_valid_reg;
    assign res.out_byte  = out_byte_reg;
    assign res.packet_id = out_id_reg;
    assign res.frame_end = out_end_reg;
    assign res.frame_ok  = out_ok_reg;

    a_payload_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == sfd_pkg::PH_PAYLOAD) |-> (left_reg != '0))
        else $error("payload phase with no bytes left");

    a_check_returns_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (phase_reg == sfd_pkg::PH_CHECK)) |=>
        ((phase_reg == sfd_pkg::PH_HUNT) && out_valid_reg && out_end_reg))
        else $error("checksum byte did not close the frame");

    a_payload_gives_data: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (phase_reg == sfd_pkg::PH_PAYLOAD)) |=>
        (out_valid_reg && !out_end_reg && !out_ok_reg))
        else $error("payload byte did not give a data result");

    a_header_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && ((phase_reg == sfd_pkg::PH_HUNT) || (phase_reg == sfd_pkg::PH_ID))
         && out_valid_reg && res.ready) |=> !out_valid_reg)
        else $error("header or id byte gave a result");

endmodule

/* tb/sfd_deframe_checker.sv */
`timescale 1ns / 1ps
// sfd_deframe_checker: watches the rx, result and register ports of the deframer,
// predicts every result transfer from the received bytes and compares them in order
// depends on sfd_pkg
module sfd_deframe_checker
    import sfd_pkg::*;
#(
    parameter int unsigned ARRAY_PAYLOAD_BYTES = ARRAY_PAYLOAD_BYTES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   rx_valid,
    input  logic                   rx_ready,
    input  byte_t                  rx_byte,
    input  logic                   res_valid,
    input  logic                   res_ready,
    input  byte_t                  out_byte,
    input  byte_t                  packet_id,
    input  logic                   frame_end,
    input  logic                   frame_ok,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output int                     fail_count,
    output int                     pending,
    output logic                   frame_open,
    output int                     result_count,
    output int                     end_count
);

    localparam byte_t ARRAY_LEN = byte_t'(ARRAY_PAYLOAD_BYTES % 256);

    typedef struct packed {
        byte_t out_byte;
        byte_t packet_id;
        logic  frame_end;
        logic  frame_ok;
    } deframed_t;

    byte_t     slot_id_q   [NUM_SLOTS];
    byte_t     slot_size_q [NUM_SLOTS];
    phase_t    phase_q;
    byte_t     id_q;
    byte_t     left_q;
    byte_t     sum_q;
    deframed_t deframed_q [$];

    // lowest matching slot wins, unknown ids fall back to slot 0
    function automatic byte_t payload_size(input byte_t id);
        int k;
        if (id == ARRAY_ID)
            return ARRAY_LEN;
        for (k = 0; k < NUM_SLOTS; k++)
        begin
            if (slot_id_q[k] == id)
                return slot_size_q[k];
        end
        return slot_size_q[0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        deframed_t want;
        byte_t     b;
        int        k;
        if (!rst_n)
        begin
            for (k = 0; k < NUM_SLOTS; k++)
            begin
                slot_id_q[k]   = '0;
                slot_size_q[k] = '0;
            end
            phase_q      = PH_HUNT;
            id_q         = '0;
            left_q       = '0;
            sum_q        = '0;
            deframed_q.delete();
            fail_count   = 0;
            result_count = 0;
            end_count    = 0;
            pending    <= 0;
            frame_open <= 1'b0;
        end
        else
        begin
            // result transfer first: it always carries the oldest prediction
            if (res_valid && res_ready)
            begin
                result_count++;
                if (frame_end)
                    end_count++;
                if (deframed_q.size() == 0)
                begin
                    fail_count++;
                    $error("unexpected result transfer: out_byte %0h packet_id %0h end %0b ok %0b",
                           out_byte, packet_id, frame_end, frame_ok);
                end
                else
                begin
                    want = deframed_q.pop_front();
                    if (out_byte !== want.out_byte)
                    begin
                        fail_count++;
                        $error("out_byte: expected %0h, got %0h", want.out_byte, out_byte);
                    end
                    if (packet_id !== want.packet_id)
                    begin
                        fail_count++;
                        $error("packet_id: expected %0h, got %0h", want.packet_id, packet_id);
                    end
                    if (frame_end !== want.frame_end)
                    begin
                        fail_count++;
                        $error("frame_end: expected %0b, got %0b", want.frame_end, frame_end);
                    end
                    if (frame_ok !== want.frame_ok)
                    begin
                        fail_count++;
                        $error("frame_ok: expected %0b, got %0b", want.frame_ok, frame_ok);
                    end
                end
            end

            if (rx_valid && rx_ready)
            begin
                b = rx_byte;
                case (phase_q)
                    PH_HUNT:
                    begin
                        if (b == HDR_BYTE)
                        begin
                            sum_q   = HDR_BYTE;
                            phase_q = PH_ID;
                        end
                    end
                    PH_ID:
                    begin
                        id_q    = b;
                        sum_q   = sum_q + b;
                        left_q  = payload_size(b);
                        phase_q = (left_q == 0) ? PH_CHECK : PH_PAYLOAD;
                    end
                    PH_PAYLOAD:
                    begin
                        sum_q  = sum_q + b;
                        left_q = left_q - 1'b1;
                        if (left_q == 0)
                            phase_q = PH_CHECK;
                        deframed_q.push_back('{out_byte: b, packet_id: id_q,
                                               frame_end: 1'b0, frame_ok: 1'b0});
                    end
                    default:
                    begin
                        deframed_q.push_back('{out_byte: b, packet_id: id_q,
                                               frame_end: 1'b1, frame_ok: (sum_q == b)});
                        phase_q = PH_HUNT;
                        left_q  = '0;
                    end
                endcase
            end

            if (cfg_we && cfg_index < NUM_CFG_REGS)
            begin
                if (cfg_index[0])
                    slot_size_q[cfg_index[SLOT_SEL_W:1]] = cfg_wdata;
                else
                    slot_id_q[cfg_index[SLOT_SEL_W:1]] = cfg_wdata;
            end

            pending    <= deframed_q.size();
            frame_open <= (phase_q != PH_HUNT);
        end
    end

endmodule

/* tb/tb_serial_frame_deframer_core.sv */
`timescale 1ns / 1ps
// tb_serial_frame_deframer_core: byte stream, slot table and receiver stall stimulus
// for the deframer, with the verdict; depends on sfd_pkg, sfd_if and sfd_deframe_checker
module tb_serial_frame_deframer_core;
    import sfd_pkg::*;

    localparam int          CLK_PERIOD      = 12;
    localparam int unsigned GAP_MAX         = 11;
    localparam int unsigned HOLD_CYCLES     = 300;
    localparam int unsigned SHORT_MAX       = 16;
    localparam int unsigned DRAIN_LIMIT     = 20000;
    localparam int          WATCHDOG_CYCLES = 400000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SLOT0_ID   = 8'd0,
        REG_SLOT0_SIZE = 8'd1,
        REG_SLOT1_ID   = 8'd2,
        REG_SLOT1_SIZE = 8'd3,
        REG_SLOT2_ID   = 8'd4,
        REG_SLOT2_SIZE = 8'd5,
        REG_SLOT3_ID   = 8'd6,
        REG_SLOT3_SIZE = 8'd7
    } cfg_reg_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    int   fail_count;
    int   pending;
    logic frame_open;
    int   result_count;
    int   end_count;

    byte_t       tbl_id   [NUM_SLOTS];
    byte_t       tbl_size [NUM_SLOTS];
    int unsigned bytes_sent;
    int unsigned long_left;
    int unsigned table_count;
    int unsigned hold_count;
    bit          tx_calm;
    bit          hold_request;

    sfd_rx_if  rx_ch ();
    sfd_res_if res_ch ();

    serial_frame_deframer_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    sfd_deframe_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_valid     (rx_ch.valid),
        .rx_ready     (rx_ch.ready),
        .rx_byte      (rx_ch.rx_byte),
        .res_valid    (res_ch.valid),
        .res_ready    (res_ch.ready),
        .out_byte     (res_ch.out_byte),
        .packet_id    (res_ch.packet_id),
        .frame_end    (res_ch.frame_end),
        .frame_ok     (res_ch.frame_ok),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .frame_open   (frame_open),
        .result_count (result_count),
        .end_count    (end_count)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int unsigned draw_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    // payload length of a frame as the loaded table defines it
    function automatic int unsigned frame_len(input byte_t id);
        int k;
        if (id == ARRAY_ID)
            return ARRAY_PAYLOAD_BYTES_DEF % 256;
        for (k = 0; k < NUM_SLOTS; k++)
        begin
            if (tbl_id[k] == id)
                return tbl_size[k];
        end
        return tbl_size[0];
    endfunction

    function automatic byte_t pick_id();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return ARRAY_ID;
        if (r < 20)
            return byte_t'($urandom);
        return tbl_id[$urandom_range(0, NUM_SLOTS - 1)];
    endfunction

    // valid stays high after the transfer so back-to-back bytes follow without a gap
    task automatic send_byte(input byte_t b);
        int unsigned gap;
        if (bytes_sent % 64 == 0)
            tx_calm = ($urandom_range(0, 3) == 0);
        gap = draw_gap(tx_calm);
        if (gap != 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge clk); while (!rx_ch.ready);
        bytes_sent++;
    endtask

    task automatic send_frame(input byte_t id, input bit good);
        byte_t       sum;
        byte_t       b;
        int unsigned len;
        int unsigned k;
        len = frame_len(id);
        sum = HDR_BYTE + id;
        send_byte(HDR_BYTE);
        send_byte(id);
        for (k = 0; k < len; k++)
        begin
            b = ($urandom_range(0, 7) == 0) ? HDR_BYTE : byte_t'($urandom);
            sum = sum + b;
            send_byte(b);
        end
        send_byte(good ? sum : sum ^ byte_t'($urandom_range(1, 255)));
    endtask

    task automatic send_random_unit();
        byte_t       id;
        int unsigned r;
        int unsigned n;
        int unsigned k;
        r = $urandom_range(0, 99);
        if (r < 72)
        begin
            id = pick_id();
            while (frame_len(id) > SHORT_MAX && long_left == 0)
                id = pick_id();
            if (frame_len(id) > SHORT_MAX)
                long_left--;
            send_frame(id, $urandom_range(0, 99) >= 15);
        end
        else if (r < 88)
        begin
            // line noise, may open a frame of its own
            n = $urandom_range(1, 6);
            for (k = 0; k < n; k++)
                send_byte(($urandom_range(0, 5) == 0) ? HDR_BYTE : byte_t'($urandom));
        end
        else
        begin
            // truncated frame, the following bytes get swallowed into it
            send_byte(HDR_BYTE);
            if ($urandom_range(0, 1) == 1)
                send_byte(pick_id());
            n = $urandom_range(0, 3);
            for (k = 0; k < n; k++)
                send_byte(byte_t'($urandom));
        end
    endtask

    // return to hunting and let every result drain before the table is touched
    task automatic settle();
        rx_ch.valid <= 1'b0;
        @(negedge clk);
        while (frame_open)
        begin
            @(posedge clk);
            send_byte(8'h00);
            rx_ch.valid <= 1'b0;
            @(negedge clk);
        end
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input byte_t val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic load_table(input byte_t id0, input byte_t sz0, input byte_t id1,
                              input byte_t sz1, input byte_t id2, input byte_t sz2,
                              input byte_t id3, input byte_t sz3);
        settle();
        tbl_id   = '{id0, id1, id2, id3};
        tbl_size = '{sz0, sz1, sz2, sz3};
        write_reg(REG_SLOT0_ID, id0);
        write_reg(REG_SLOT0_SIZE, sz0);
        write_reg(REG_SLOT1_ID, id1);
        write_reg(REG_SLOT1_SIZE, sz1);
        write_reg(REG_SLOT2_ID, id2);
        write_reg(REG_SLOT2_SIZE, sz2);
        write_reg(REG_SLOT3_ID, id3);
        write_reg(REG_SLOT3_SIZE, sz3);
        // out of range index must leave the table alone
        write_reg(CFG_INDEX_W'(NUM_CFG_REGS + $urandom_range(0, 255 - NUM_CFG_REGS)),
                  byte_t'($urandom));
        cfg_we <= 1'b0;
        table_count++;
    endtask

    task automatic load_random_table(input byte_t max_size);
        load_table(byte_t'($urandom_range(0, 254)), byte_t'($urandom_range(0, max_size)),
                   byte_t'($urandom_range(0, 254)), byte_t'($urandom_range(0, max_size)),
                   byte_t'($urandom_range(0, 254)), byte_t'($urandom_range(0, max_size)),
                   byte_t'($urandom_range(0, 254)), byte_t'($urandom_range(0, max_size)));
    endtask

    task automatic run_random(input int unsigned until_bytes, input int unsigned longs,
                              input bit with_hold);
        long_left = longs;
        while (bytes_sent < until_bytes)
        begin
            if (with_hold && hold_count == 0 && !hold_request
                && bytes_sent > until_bytes - 250)
                hold_request = 1'b1;
            send_random_unit();
        end
    endtask

    // receiver: random stall per result, calm stretches and one long hold-off
    initial
    begin : receiver
        int unsigned gap;
        int unsigned taken;
        bit          rx_calm;
        res_ch.ready <= 1'b0;
        taken   = 0;
        rx_calm = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                hold_count++;
            end
            if (taken % 64 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
            gap = draw_gap(rx_calm);
            if (gap != 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
            taken++;
        end
    end

    initial
    begin : stimulus
        int unsigned waited;
        rst_n         = 1'b0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= '0;
        cfg_we        <= 1'b0;
        cfg_index     <= '0;
        cfg_wdata     <= '0;
        bytes_sent    = 0;
        long_left     = 0;
        table_count   = 0;
        hold_count    = 0;
        tx_calm       = 1'b0;
        hold_request  = 1'b0;
        tbl_id        = '{default: '0};
        tbl_size      = '{default: '0};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // cleared table: skipped bytes, zero length frame, unknown id with bad checksum
        send_byte(8'h00);
        send_byte(8'hff);
        send_frame(8'h00, 1'b1);
        send_frame(8'h12, 1'b0);

        load_table(8'h10, 8'd2, 8'h20, 8'd0, 8'h20, 8'd5, ARRAY_ID, 8'd3);
        send_frame(8'h20, 1'b1);
        send_frame(8'h30, 1'b1);
        send_frame(8'h10, 1'b0);
        // header bytes as payload
        send_byte(HDR_BYTE);
        send_byte(8'h10);
        send_byte(HDR_BYTE);
        send_byte(HDR_BYTE);
        send_byte(HDR_BYTE + 8'h10 + HDR_BYTE + HDR_BYTE);
        // array frame while a slot claims id ff
        send_frame(ARRAY_ID, 1'b1);

        load_random_table(8'd8);
        run_random(420, 2, 1'b0);

        load_table(8'h00, 8'd255, 8'hfe, 8'd0, ARRAY_ID, 8'd255,
                   byte_t'($urandom_range(1, 253)), byte_t'($urandom_range(1, 8)));
        run_random(840, 1, 1'b0);

        load_random_table(8'd8);
        run_random(1270, 1, 1'b1);

        rx_ch.valid <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (pending != 0)
            $error("%0d predicted results never arrived", pending);

        $display("sent %0d bytes over %0d slot tables, %0d long receiver hold-offs",
                 bytes_sent, table_count, hold_count);
        $display("checked %0d result transfers, %0d of them frame ends",
                 result_count, end_count);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : watchdog
        #(WATCHDOG_CYCLES * CLK_PERIOD);
        $error("run did not complete in time");
        $display("Simulation FAILED");
        $finish;
    end

endmodule
